FILE: rtl/core/pdrw_pkg.sv
`timescale 1ns / 1ps

package pdrw_pkg;

  localparam int unsigned WordWidth   = 16;
  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned OffWidth    = 33;
  localparam int unsigned DeltaWidth  = 64;
  localparam int unsigned EntryWidth  = 31;
  localparam int unsigned TypeShift   = 12;
  localparam int unsigned PaddrWidth  = 5;
  localparam int unsigned PdataWidth  = 64;

  localparam logic [11:0] OffsetMask  = 12'hFFF;
  localparam logic [3:0]  TypeDir64   = 4'd10;
  localparam logic [3:0]  TypeAbsPad  = 4'd0;
  localparam logic [31:0] MinBlockLen = 32'd8;

  typedef enum logic [1:0] {
    REG_IMAGE_SIZE = 2'd0,
    REG_DIR_SIZE   = 2'd1,
    REG_DELTA      = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_PATCH   = 3'd1,
    ST_PAD     = 3'd2,
    ST_SMALL   = 3'd3,
    ST_ODD     = 3'd4,
    ST_BOUNDS  = 3'd5,
    ST_TYPE    = 3'd6,
    ST_IGNORED = 3'd7
  } status_e;

  typedef enum logic [4:0] {
    PH_PAGE_LO = 5'b00001,
    PH_PAGE_HI = 5'b00010,
    PH_SIZE_LO = 5'b00100,
    PH_SIZE_HI = 5'b01000,
    PH_ENTRIES = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                  op;
    logic [WordWidth-1:0]  word;
  } in_word_t;

  typedef struct packed {
    status_e               status;
    logic [OffWidth-1:0]   patch_offset;
    logic [DeltaWidth-1:0] add_value;
    logic                  last;
  } out_word_t;

endpackage

FILE: rtl/core/pe_dir64_relocation_walker_top.sv
`timescale 1ns / 1ps

// Walks a PE base-relocation directory delivered as one 16-bit word per input word and returns
// one result word per directory word (a restart word returns none); DIR64 entries give the patch
// offset and the delta to add, and the first error stops the walk until the next restart. Each
// input word is decoded combinationally between the walk state and the result register, so one
// word is accepted every clock as long as the result register is empty or being drained, and a
// result appears in the cycle after its input word is taken. Program image_size, directory_size and
// relocation_delta over the APB port at byte addresses 0x0, 0x8 and 0x10 while the walker is idle.
module pe_dir64_relocation_walker_top
  import pdrw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o
);

  logic [AddrWidth-1:0]  image_size_q, dir_size_q;
  logic [DeltaWidth-1:0] delta_q;
  reg_idx_e              reg_idx;
  logic                  cfg_we;

  phase_e                phase_q, phase_d;
  logic [AddrWidth-1:0]  page_q, page_d;
  logic [WordWidth-1:0]  len_lo_q, len_lo_d;
  logic [EntryWidth-1:0] left_q, left_d;
  logic [AddrWidth-1:0]  seen_q, seen_d;
  logic                  halted_q, halted_d;

  logic                  out_valid_q, out_valid_d;
  out_word_t             out_data_q, out_data_d;

  logic                  in_fire, active;
  logic [AddrWidth:0]    seen_sum, target;
  logic [AddrWidth-1:0]  block_len, len_less8;
  logic [EntryWidth-1:0] left_dec;
  logic [3:0]            ent_type;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PaddrWidth-1:3]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_SIZE: prdata = {32'd0, image_size_q};
      REG_DIR_SIZE:   prdata = {32'd0, dir_size_q};
      REG_DELTA:      prdata = delta_q;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= '0;
      dir_size_q   <= '0;
      delta_q      <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_IMAGE_SIZE: image_size_q <= pwdata[AddrWidth-1:0];
        REG_DIR_SIZE:   dir_size_q   <= pwdata[AddrWidth-1:0];
        REG_DELTA:      delta_q      <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign active    = (delta_q != '0) && (dir_size_q != '0) && !halted_q && (seen_q < dir_size_q);
  assign seen_sum  = {1'b0, seen_q} + 33'd2;
  assign block_len = {in_data_i.word, len_lo_q};
  assign len_less8 = block_len - MinBlockLen;
  assign left_dec  = (left_q != '0) ? left_q - 31'd1 : left_q;
  assign ent_type  = in_data_i.word[WordWidth-1:TypeShift];
  assign target    = {1'b0, page_q} + {21'd0, in_data_i.word[TypeShift-1:0] & OffsetMask};

  always_comb begin
    phase_d    = phase_q;
    page_d     = page_q;
    len_lo_d   = len_lo_q;
    left_d     = left_q;
    seen_d     = seen_q;
    halted_d   = halted_q;
    out_data_d = '{status: ST_IGNORED, patch_offset: '0, add_value: '0, last: 1'b0};

    if (in_data_i.op) begin
      phase_d  = PH_PAGE_LO;
      page_d   = '0;
      len_lo_d = '0;
      left_d   = '0;
      seen_d   = '0;
      halted_d = 1'b0;
    end else if (active) begin
      seen_d          = seen_sum[AddrWidth] ? '1 : seen_sum[AddrWidth-1:0];
      out_data_d.last = seen_sum >= {1'b0, dir_size_q};
      unique case (phase_q)
        PH_PAGE_LO: begin
          page_d            = {16'd0, in_data_i.word};
          out_data_d.status = ST_HEADER;
          phase_d           = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          page_d            = {in_data_i.word, page_q[WordWidth-1:0]};
          out_data_d.status = ST_HEADER;
          phase_d           = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          len_lo_d          = in_data_i.word;
          out_data_d.status = ST_HEADER;
          phase_d           = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          priority if (block_len < MinBlockLen) begin
            out_data_d.status = ST_SMALL;
            halted_d          = 1'b1;
            phase_d           = PH_PAGE_LO;
          end else if (block_len[0]) begin
            out_data_d.status = ST_ODD;
            halted_d          = 1'b1;
            phase_d           = PH_PAGE_LO;
          end else begin
            out_data_d.status = ST_HEADER;
            left_d            = len_less8[AddrWidth-1:1];
            phase_d           = (len_less8[AddrWidth-1:1] == '0) ? PH_PAGE_LO : PH_ENTRIES;
          end
        end
        PH_ENTRIES: begin
          priority if (ent_type == TypeDir64) begin
            if (target >= {1'b0, image_size_q}) begin
              out_data_d.status = ST_BOUNDS;
              halted_d          = 1'b1;
            end else begin
              out_data_d.status       = ST_PATCH;
              out_data_d.patch_offset = target;
              out_data_d.add_value    = delta_q;
            end
          end else if (ent_type == TypeAbsPad) begin
            out_data_d.status = ST_PAD;
          end else begin
            out_data_d.status = ST_TYPE;
            halted_d          = 1'b1;
          end
          left_d = left_dec;
          if (left_dec == '0 || halted_d) begin
            phase_d = PH_PAGE_LO;
          end
        end
        default: phase_d = PH_PAGE_LO;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && !in_data_i.op) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PAGE_LO;
      page_q      <= '0;
      len_lo_q    <= '0;
      left_q      <= '0;
      seen_q      <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q  <= phase_d;
        page_q   <= page_d;
        len_lo_q <= len_lo_d;
        left_q   <= left_d;
        seen_q   <= seen_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_data_i.op) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import pdrw_pkg::*;

  localparam logic OpWord    = 1'b0;
  localparam logic OpRestart = 1'b1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [PdataWidth-1:0] pwdata = '0;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_word_t             out_data_o;

  pe_dir64_relocation_walker_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Walk state and register copies for the prediction.
  logic [31:0] img_size_cfg = '0;
  logic [31:0] dir_size_cfg = '0;
  logic [63:0] delta_cfg = '0;
  phase_e      walk_phase = PH_PAGE_LO;
  logic [31:0] blk_page = '0;
  logic [31:0] blk_len = '0;
  logic [30:0] ents_left = '0;
  logic [31:0] bytes_seen = '0;
  logic        walk_halted = 1'b0;

  in_word_t  staged_words[$];
  in_word_t  pending_words[$];
  out_word_t due_results[$];
  int        mismatches = 0;

  logic        word_taken = 1'b0;
  bit          idle_en = 1'b1;
  int          gap_left = 0;
  int          burst_left = 0;
  logic [15:0] stall_bits = '0;
  logic [5:0]  stall_cnt = '0;

  task automatic advance_walk(input in_word_t w_in);
    out_word_t   res;
    logic [32:0] seen;
    logic [32:0] target;
    logic [3:0]  etype;
    if (w_in.op == OpRestart) begin
      walk_phase  = PH_PAGE_LO;
      blk_page    = '0;
      blk_len     = '0;
      ents_left   = '0;
      bytes_seen  = '0;
      walk_halted = 1'b0;
      return;
    end
    res.status       = ST_IGNORED;
    res.patch_offset = '0;
    res.add_value    = '0;
    res.last         = 1'b0;
    if (delta_cfg != 0 && dir_size_cfg != 0 && !walk_halted && bytes_seen < dir_size_cfg) begin
      seen       = {1'b0, bytes_seen} + 33'd2;
      bytes_seen = seen[32] ? 32'hFFFF_FFFF : seen[31:0];
      res.last   = (seen >= {1'b0, dir_size_cfg});
      case (walk_phase)
        PH_PAGE_LO: begin
          blk_page   = {16'h0, w_in.word};
          res.status = ST_HEADER;
          walk_phase = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          blk_page[31:16] = w_in.word;
          res.status      = ST_HEADER;
          walk_phase      = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          blk_len    = {16'h0, w_in.word};
          res.status = ST_HEADER;
          walk_phase = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          blk_len[31:16] = w_in.word;
          if (blk_len < MinBlockLen) begin
            res.status  = ST_SMALL;
            walk_halted = 1'b1;
            walk_phase  = PH_PAGE_LO;
          end else if (blk_len[0]) begin
            res.status  = ST_ODD;
            walk_halted = 1'b1;
            walk_phase  = PH_PAGE_LO;
          end else begin
            res.status = ST_HEADER;
            ents_left  = 31'((blk_len - MinBlockLen) >> 1);
            walk_phase = (ents_left == 0) ? PH_PAGE_LO : PH_ENTRIES;
          end
        end
        default: begin
          etype  = 4'(w_in.word >> TypeShift);
          target = {1'b0, blk_page} + {21'h0, w_in.word[11:0] & OffsetMask};
          if (etype == TypeDir64) begin
            if (target >= {1'b0, img_size_cfg}) begin
              res.status  = ST_BOUNDS;
              walk_halted = 1'b1;
            end else begin
              res.status       = ST_PATCH;
              res.patch_offset = target;
              res.add_value    = delta_cfg;
            end
          end else if (etype == TypeAbsPad) begin
            res.status = ST_PAD;
          end else begin
            res.status  = ST_TYPE;
            walk_halted = 1'b1;
          end
          if (ents_left != 0) ents_left = ents_left - 31'd1;
          if (ents_left == 0 || walk_halted) walk_phase = PH_PAGE_LO;
        end
      endcase
    end
    due_results.push_back(res);
  endtask

  always @(posedge clk_i) begin : check_results
    out_word_t want;
    word_taken <= rst_ni && in_valid && in_ready_o;
    if (rst_ni && in_valid && in_ready_o) advance_walk(in_data);
    if (rst_ni && out_valid_o && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.patch_offset !== want.patch_offset) begin
          $error("patch_offset: expected %h, got %h", want.patch_offset,
                 out_data_o.patch_offset);
          mismatches++;
        end
        if (out_data_o.add_value !== want.add_value) begin
          $error("add_value: expected %h, got %h", want.add_value, out_data_o.add_value);
          mismatches++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid || word_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          if (!idle_en) gap_left <= 0;
          else if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 8);
          else gap_left <= $urandom_range(0, 2);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == 0) stall_bits <= 16'($urandom);
    else stall_bits <= {stall_bits[0], stall_bits[15:1]};
    out_ready <= !(idle_en && stall_bits[0] && stall_bits[1]);
  end

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrWidth'({idx, 3'b000});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_IMAGE_SIZE: img_size_cfg = data[31:0];
      REG_DIR_SIZE:   dir_size_cfg = data[31:0];
      REG_DELTA:      delta_cfg = data;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic stage(input logic op, input logic [15:0] w);
    in_word_t it;
    it.op   = op;
    it.word = w;
    staged_words.push_back(it);
  endtask

  task automatic run_phase(input logic [31:0] img, input logic [31:0] dsz,
                           input logic [63:0] dlt);
    apb_write(REG_IMAGE_SIZE, {32'h0, img});
    apb_write(REG_DIR_SIZE, {32'h0, dsz});
    apb_write(REG_DELTA, dlt);
    while (staged_words.size() > 0) pending_words.push_back(staged_words.pop_front());
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic stage_walk(input logic [31:0] dsz, input logic [31:0] img,
                            inout int dir_words);
    int          budget;
    int          bytes;
    int          n;
    int          pick;
    logic [31:0] page;
    logic [31:0] blen;
    logic [3:0]  ty;
    bit          stop;
    budget = (dsz > 200) ? 200 : int'(dsz);
    bytes  = 0;
    stop   = 1'b0;
    stage(OpRestart, 16'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12))
        stage(($urandom_range(0, 5) == 0) ? OpRestart : OpWord, 16'($urandom));
      return;
    end
    while (bytes < budget && !stop) begin
      if (img != 0 && $urandom_range(0, 9) != 0)
        page = $urandom_range(0, img - 1) & 32'hFFFF_F000;
      else
        page = $urandom;
      pick = $urandom_range(0, 39);
      n    = $urandom_range(0, 10);
      if (pick == 0) begin
        blen = $urandom_range(0, 7);
        n    = 0;
        stop = 1'b1;
      end else if (pick == 1) begin
        blen = {($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0, 15'($urandom), 1'b1};
        if (blen < MinBlockLen) blen = 32'd9;
        n    = 0;
        stop = 1'b1;
      end else if (pick < 4) begin
        // Oversized block: the directory ends inside it.
        blen = {1'b1, 15'($urandom), 15'($urandom), 1'b0};
        n    = (budget - bytes - 8) / 2 + 1;
        if (n < 0) n = 0;
      end else begin
        blen = 32'(8 + 2 * n);
      end
      stage(OpWord, page[15:0]);
      stage(OpWord, page[31:16]);
      stage(OpWord, blen[15:0]);
      stage(OpWord, blen[31:16]);
      dir_words += 4;
      for (int k = 0; k < n && !stop; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          stage(OpWord, {TypeDir64, 12'($urandom)});
        end else if (pick < 97) begin
          stage(OpWord, {TypeAbsPad, 12'($urandom)});
        end else begin
          ty = 4'($urandom_range(1, 15));
          if (ty == TypeDir64) ty = 4'd11;
          stage(OpWord, {ty, 12'($urandom)});
          stop = 1'b1;
        end
        dir_words++;
      end
      bytes += 8 + 2 * n;
    end
    repeat ($urandom_range(0, 2)) stage(OpWord, 16'($urandom));
  endtask

  initial begin
    int          dir_words;
    int          walk_words;
    logic [31:0] img;
    logic [31:0] dsz;
    logic [63:0] dlt;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    stage(OpRestart, 16'hFFFF);
    stage(OpWord, 16'hFFFF);
    stage(OpWord, 16'h0000);
    run_phase(32'h0, 32'h0, 64'h0);

    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h1000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h000E);
    stage(OpWord, 16'h0000);
    stage(OpWord, {TypeDir64, 12'h000});
    stage(OpWord, {TypeAbsPad, 12'h000});
    stage(OpWord, {TypeDir64, 12'hFFF});
    stage(OpWord, 16'hFFFF);
    stage(OpWord, 16'hFFFF);
    stage(OpWord, 16'h0008);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'hF000);
    stage(OpWord, 16'hFFFF);
    stage(OpWord, 16'h000A);
    stage(OpWord, 16'h0000);
    stage(OpWord, {TypeDir64, 12'hFFF});
    stage(OpWord, 16'h1234);
    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h0007);
    stage(OpWord, 16'h0000);
    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h0009);
    stage(OpWord, 16'h0000);
    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h000A);
    stage(OpWord, 16'h0000);
    stage(OpWord, 16'h5123);
    run_phase(32'h0000_3000, 32'h40, 64'hFFFF_FFFF_FFFF_FFFF);

    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h0001);
    stage(OpWord, 16'h0002);
    stage(OpWord, 16'h0003);
    stage(OpWord, 16'h0004);
    run_phase(32'h0, 32'd5, 64'h1);

    stage(OpRestart, 16'h0000);
    stage(OpWord, 16'h0000);
    stage(OpWord, {TypeDir64, 12'h000});
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);

    dir_words = 0;
    while (dir_words < 900) begin
      pick_config(img, dsz, dlt);
      idle_en    = ($urandom_range(0, 4) != 0);
      walk_words = 0;
      repeat ($urandom_range(1, 4)) stage_walk(dsz, img, walk_words);
      if (dsz != 0 && dlt != 0) dir_words += walk_words;
      run_phase(img, dsz, dlt);
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  task automatic pick_config(output logic [31:0] img, output logic [31:0] dsz,
                             output logic [63:0] dlt);
    case ($urandom_range(0, 9))
      0:       img = 32'hFFFF_FFFF;
      1:       img = 32'h0;
      default: img = $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
    endcase
    case ($urandom_range(0, 19))
      0:       dsz = 32'h0;
      1:       dsz = 32'hFFFF_FFFF;
      default: dsz = $urandom_range(8, 200);
    endcase
    case ($urandom_range(0, 19))
      0:       dlt = 64'h0;
      1:       dlt = 64'hFFFF_FFFF_FFFF_FFFF;
      2:       dlt = 64'h1;
      default: dlt = {32'($urandom), 32'($urandom)};
    endcase
  endtask

endmodule
